// ===== design/gc_pkg.sv =====
// Shared types, register map and helper functions for the GPIO controller.
package gc_pkg;

  localparam int PIN_COUNT  = 54;
  localparam int WORD_W     = 32;
  localparam int HI_W       = PIN_COUNT - WORD_W;
  localparam int OFS_W      = 6;

  localparam int FSEL_WORDS = 6;
  localparam int FSEL_PINS  = 10;
  localparam int FSEL_BITS  = 3;
  localparam int FSEL_W     = FSEL_PINS * FSEL_BITS;
  localparam int FSEL_IDX_W = $clog2(FSEL_WORDS);

  localparam int PULL_WORDS = 4;
  localparam int PULL_PINS  = 16;
  localparam int PULL_BITS  = 2;
  localparam int PULL_IDX_W = $clog2(PULL_WORDS);

  localparam logic [FSEL_BITS-1:0] FSEL_CODE_OUT = 3'h1;

  // Register word offsets (byte offset / 4)
  localparam logic [OFS_W-1:0] OFS_FSEL_END = OFS_W'(FSEL_WORDS);
  localparam logic [OFS_W-1:0] OFS_SET      = 6'd7;
  localparam logic [OFS_W-1:0] OFS_CLR      = 6'd10;
  localparam logic [OFS_W-1:0] OFS_LEV      = 6'd13;
  localparam logic [OFS_W-1:0] OFS_EDS      = 6'd16;
  localparam logic [OFS_W-1:0] OFS_REN      = 6'd19;
  localparam logic [OFS_W-1:0] OFS_FEN      = 6'd22;
  localparam logic [OFS_W-1:0] OFS_HEN      = 6'd25;
  localparam logic [OFS_W-1:0] OFS_LEN      = 6'd28;
  localparam logic [OFS_W-1:0] OFS_PULL     = 6'd57;
  localparam logic [OFS_W-1:0] OFS_PULL_END = OFS_PULL + OFS_W'(PULL_WORDS);

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2
  } gc_cmd_t;

  typedef logic [PIN_COUNT-1:0] gc_pins_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [OFS_W-1:0]  reg_offset;
    logic [WORD_W-1:0] write_data;
    logic [WORD_W-1:0] pins_in_low;
    logic [HI_W-1:0]   pins_in_high;
  } gc_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic [WORD_W-1:0] drive_low;
    logic [HI_W-1:0]   drive_high;
    logic [WORD_W-1:0] out_enable_low;
    logic [HI_W-1:0]   out_enable_high;
    logic              irq;
  } gc_result_t;

  function automatic logic in_pair(logic [OFS_W-1:0] off, logic [OFS_W-1:0] base);
    return (off == base) || (off == (base + 6'd1));
  endfunction

  function automatic logic [FSEL_W-1:0] fsel_mask(int w);
    logic [FSEL_W-1:0] m;
    m = '0;
    for (int i = 0; i < FSEL_PINS; i++) begin
      if (w * FSEL_PINS + i < PIN_COUNT) m[i*FSEL_BITS +: FSEL_BITS] = '1;
    end
    return m;
  endfunction

  function automatic logic [WORD_W-1:0] pull_mask(int w);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int i = 0; i < PULL_PINS; i++) begin
      if (w * PULL_PINS + i < PIN_COUNT) m[i*PULL_BITS +: PULL_BITS] = '1;
    end
    return m;
  endfunction

  // Place a bus word into the low or high bank of a pin vector
  function automatic gc_pins_t put_half(gc_pins_t r, logic bank, logic [WORD_W-1:0] d);
    gc_pins_t hm;
    gc_pins_t wd;
    hm = '0;
    wd = '0;
    if (bank) begin
      hm[PIN_COUNT-1:WORD_W] = '1;
      wd[PIN_COUNT-1:WORD_W] = d[HI_W-1:0];
    end else begin
      hm[WORD_W-1:0] = '1;
      wd[WORD_W-1:0] = d;
    end
    return (r & ~hm) | (wd & hm);
  endfunction

  function automatic logic [WORD_W-1:0] half_of(gc_pins_t r, logic bank);
    return bank ? WORD_W'(r[PIN_COUNT-1:WORD_W]) : r[WORD_W-1:0];
  endfunction

endpackage

// ===== design/gc_if.sv =====
// Valid/ready channel interfaces for bus/tick words in and result words out.
interface gc_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       cmd;
  logic [gc_pkg::OFS_W-1:0]         reg_offset;
  logic [gc_pkg::WORD_W-1:0]        write_data;
  logic [gc_pkg::WORD_W-1:0]        pins_in_low;
  logic [gc_pkg::HI_W-1:0]          pins_in_high;

  modport source (output valid, cmd, reg_offset, write_data, pins_in_low, pins_in_high,
                  input ready);
  modport sink (input valid, cmd, reg_offset, write_data, pins_in_low, pins_in_high,
                output ready);
endinterface

interface gc_out_if;
  logic                             valid;
  logic                             ready;
  logic [gc_pkg::WORD_W-1:0]        read_data;
  logic [gc_pkg::WORD_W-1:0]        drive_low;
  logic [gc_pkg::HI_W-1:0]          drive_high;
  logic [gc_pkg::WORD_W-1:0]        out_enable_low;
  logic [gc_pkg::HI_W-1:0]          out_enable_high;
  logic                             irq;

  modport source (output valid, read_data, drive_low, drive_high, out_enable_low,
                  out_enable_high, irq, input ready);
  modport sink (input valid, read_data, drive_low, drive_high, out_enable_low,
                out_enable_high, irq, output ready);
endinterface

// ===== design/gc_in_stage.sv =====
// Input register stage: captures one word per cycle, holds it while downstream stalls.
module gc_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  gc_in_if.sink            in_ch,
  input  logic             adv,
  output logic             vld,
  output gc_pkg::gc_item_t item
);

  logic             vld_r;
  logic             vld_nxt;
  gc_pkg::gc_item_t item_r;
  logic             take;

  assign in_ch.ready = !vld_r || adv;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (adv) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= '{cmd:          in_ch.cmd,
                  reg_offset:   in_ch.reg_offset,
                  write_data:   in_ch.write_data,
                  pins_in_low:  in_ch.pins_in_low,
                  pins_in_high: in_ch.pins_in_high};
    end
  end

  assign vld  = vld_r;
  assign item = item_r;

endmodule

// ===== design/gc_core.sv =====
// GPIO register file, event detection and next-result logic.
module gc_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  gc_pkg::gc_item_t   item,
  output gc_pkg::gc_result_t result
);

  logic [gc_pkg::FSEL_W-1:0] fsel_r   [gc_pkg::FSEL_WORDS];
  logic [gc_pkg::FSEL_W-1:0] fsel_nxt [gc_pkg::FSEL_WORDS];
  logic [gc_pkg::WORD_W-1:0] pull_r   [gc_pkg::PULL_WORDS];
  logic [gc_pkg::WORD_W-1:0] pull_nxt [gc_pkg::PULL_WORDS];

  gc_pkg::gc_pins_t latch_r, latch_nxt;
  gc_pkg::gc_pins_t eds_r, eds_nxt;
  gc_pkg::gc_pins_t ren_r, ren_nxt;
  gc_pkg::gc_pins_t fen_r, fen_nxt;
  gc_pkg::gc_pins_t hen_r, hen_nxt;
  gc_pkg::gc_pins_t len_r, len_nxt;
  gc_pkg::gc_pins_t lev_r, lev_nxt;

  logic [gc_pkg::OFS_W-1:0]      off;
  logic [gc_pkg::OFS_W-1:0]      pull_rel;
  logic [gc_pkg::FSEL_IDX_W-1:0] fsel_idx;
  logic [gc_pkg::PULL_IDX_W-1:0] pull_idx;
  logic                          fsel_hit;
  logic                          pull_hit;
  logic [gc_pkg::WORD_W-1:0]     d;
  logic [gc_pkg::WORD_W-1:0]     rd;
  gc_pkg::gc_pins_t              lv;
  gc_pkg::gc_pins_t              hit;
  gc_pkg::gc_pins_t              oe;

  assign off      = item.reg_offset;
  assign d        = item.write_data;
  assign pull_rel = off - gc_pkg::OFS_PULL;
  assign fsel_idx = off[gc_pkg::FSEL_IDX_W-1:0];
  assign pull_idx = pull_rel[gc_pkg::PULL_IDX_W-1:0];
  assign fsel_hit = off < gc_pkg::OFS_FSEL_END;
  assign pull_hit = (off >= gc_pkg::OFS_PULL) && (off < gc_pkg::OFS_PULL_END);
  assign lv       = {item.pins_in_high, item.pins_in_low};
  assign hit      = (lv & ~lev_r & ren_r) | (~lv & lev_r & fen_r) |
                    (lv & hen_r) | (~lv & len_r);

  // Register read, from state before this word
  always_comb begin
    rd = '0;
    if (fsel_hit) begin
      rd = gc_pkg::WORD_W'(fsel_r[fsel_idx]);
    end else if (gc_pkg::in_pair(off, gc_pkg::OFS_LEV)) begin
      rd = gc_pkg::half_of(lev_r, off != gc_pkg::OFS_LEV);
    end else if (gc_pkg::in_pair(off, gc_pkg::OFS_EDS)) begin
      rd = gc_pkg::half_of(eds_r, off != gc_pkg::OFS_EDS);
    end else if (gc_pkg::in_pair(off, gc_pkg::OFS_REN)) begin
      rd = gc_pkg::half_of(ren_r, off != gc_pkg::OFS_REN);
    end else if (gc_pkg::in_pair(off, gc_pkg::OFS_FEN)) begin
      rd = gc_pkg::half_of(fen_r, off != gc_pkg::OFS_FEN);
    end else if (gc_pkg::in_pair(off, gc_pkg::OFS_HEN)) begin
      rd = gc_pkg::half_of(hen_r, off != gc_pkg::OFS_HEN);
    end else if (gc_pkg::in_pair(off, gc_pkg::OFS_LEN)) begin
      rd = gc_pkg::half_of(len_r, off != gc_pkg::OFS_LEN);
    end else if (pull_hit) begin
      rd = pull_r[pull_idx];
    end
  end

  always_comb begin
    fsel_nxt  = fsel_r;
    pull_nxt  = pull_r;
    latch_nxt = latch_r;
    eds_nxt   = eds_r;
    ren_nxt   = ren_r;
    fen_nxt   = fen_r;
    hen_nxt   = hen_r;
    len_nxt   = len_r;
    lev_nxt   = lev_r;
    if (go) begin
      case (item.cmd)
        gc_pkg::CMD_WRITE: begin
          if (fsel_hit) begin
            for (int w = 0; w < gc_pkg::FSEL_WORDS; w++) begin
              if (fsel_idx == gc_pkg::FSEL_IDX_W'(w)) begin
                fsel_nxt[w] = d[gc_pkg::FSEL_W-1:0] & gc_pkg::fsel_mask(w);
              end
            end
          end else if (gc_pkg::in_pair(off, gc_pkg::OFS_SET)) begin
            latch_nxt = latch_r | gc_pkg::put_half('0, off != gc_pkg::OFS_SET, d);
          end else if (gc_pkg::in_pair(off, gc_pkg::OFS_CLR)) begin
            latch_nxt = latch_r & ~gc_pkg::put_half('0, off != gc_pkg::OFS_CLR, d);
          end else if (gc_pkg::in_pair(off, gc_pkg::OFS_EDS)) begin
            // write ones to clear
            eds_nxt = eds_r & ~gc_pkg::put_half('0, off != gc_pkg::OFS_EDS, d);
          end else if (gc_pkg::in_pair(off, gc_pkg::OFS_REN)) begin
            ren_nxt = gc_pkg::put_half(ren_r, off != gc_pkg::OFS_REN, d);
          end else if (gc_pkg::in_pair(off, gc_pkg::OFS_FEN)) begin
            fen_nxt = gc_pkg::put_half(fen_r, off != gc_pkg::OFS_FEN, d);
          end else if (gc_pkg::in_pair(off, gc_pkg::OFS_HEN)) begin
            hen_nxt = gc_pkg::put_half(hen_r, off != gc_pkg::OFS_HEN, d);
          end else if (gc_pkg::in_pair(off, gc_pkg::OFS_LEN)) begin
            len_nxt = gc_pkg::put_half(len_r, off != gc_pkg::OFS_LEN, d);
          end else if (pull_hit) begin
            for (int w = 0; w < gc_pkg::PULL_WORDS; w++) begin
              if (pull_idx == gc_pkg::PULL_IDX_W'(w)) begin
                pull_nxt[w] = d & gc_pkg::pull_mask(w);
              end
            end
          end
        end
        gc_pkg::CMD_TICK: begin
          eds_nxt = eds_r | hit;
          lev_nxt = lv;
        end
        default: ;
      endcase
    end
  end

  // Output enables from the updated function select
  always_comb begin
    oe = '0;
    for (int w = 0; w < gc_pkg::FSEL_WORDS; w++) begin
      for (int i = 0; i < gc_pkg::FSEL_PINS; i++) begin
        if (w * gc_pkg::FSEL_PINS + i < gc_pkg::PIN_COUNT) begin
          oe[w*gc_pkg::FSEL_PINS + i] =
            fsel_nxt[w][i*gc_pkg::FSEL_BITS +: gc_pkg::FSEL_BITS] == gc_pkg::FSEL_CODE_OUT;
        end
      end
    end
  end

  always_comb begin
    result.read_data       = (item.cmd == gc_pkg::CMD_READ) ? rd : '0;
    result.drive_low       = latch_nxt[gc_pkg::WORD_W-1:0];
    result.drive_high      = latch_nxt[gc_pkg::PIN_COUNT-1:gc_pkg::WORD_W];
    result.out_enable_low  = oe[gc_pkg::WORD_W-1:0];
    result.out_enable_high = oe[gc_pkg::PIN_COUNT-1:gc_pkg::WORD_W];
    result.irq             = |eds_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < gc_pkg::FSEL_WORDS; w++) fsel_r[w] <= '0;
      for (int w = 0; w < gc_pkg::PULL_WORDS; w++) pull_r[w] <= '0;
      latch_r <= '0;
      eds_r   <= '0;
      ren_r   <= '0;
      fen_r   <= '0;
      hen_r   <= '0;
      len_r   <= '0;
      lev_r   <= '0;
    end else begin
      fsel_r  <= fsel_nxt;
      pull_r  <= pull_nxt;
      latch_r <= latch_nxt;
      eds_r   <= eds_nxt;
      ren_r   <= ren_nxt;
      fen_r   <= fen_nxt;
      hen_r   <= hen_nxt;
      len_r   <= len_nxt;
      lev_r   <= lev_nxt;
    end
  end

endmodule

// ===== design/gpio_controller_with_event_detect.sv =====
// GPIO register block with event detection: input stage, register core, result register.
// An accepted word waits in the input register until it advances to the result register.
// Throughput: one word per cycle while results are taken; the input register and the
// result register let a new word in while a finished result still waits to be taken.
// Reset (synchronous, active low) clears all GPIO registers, the pin level history and
// both stage valids.
module gpio_controller_with_event_detect (
  input  logic     clk,
  input  logic     rst_n,
  gc_in_if.sink    in_ch,
  gc_out_if.source out_ch
);

  logic               s1_v;
  gc_pkg::gc_item_t   s1_item;
  logic               adv;
  gc_pkg::gc_result_t res;
  gc_pkg::gc_result_t res_r;
  logic               out_v_r;
  logic               out_v_nxt;

  assign adv = s1_v && (!out_v_r || out_ch.ready);

  gc_in_stage u_in (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .adv   (adv),
    .vld   (s1_v),
    .item  (s1_item)
  );

  gc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (adv),
    .item   (s1_item),
    .result (res)
  );

  always_comb begin
    out_v_nxt = out_v_r;
    if (adv) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.read_data       = res_r.read_data;
  assign out_ch.drive_low       = res_r.drive_low;
  assign out_ch.drive_high      = res_r.drive_high;
  assign out_ch.out_enable_low  = res_r.out_enable_low;
  assign out_ch.out_enable_high = res_r.out_enable_high;
  assign out_ch.irq             = res_r.irq;

  a_reset_empty : assert property (@(posedge clk) !rst_n |=> !out_v_r && !s1_v)
    else $error("pipeline not empty after reset");

  a_nonread_zero : assert property (@(posedge clk) disable iff (!rst_n)
    adv && (s1_item.cmd != gc_pkg::CMD_READ) |=> res_r.read_data == '0)
    else $error("non-read word returned read data");

  a_empty_ready : assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v |-> in_ch.ready)
    else $error("input stalled with empty stage");

  a_adv_fills : assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_v_r)
    else $error("advanced word lost before result register");

endmodule
